### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked concurrent assertions with async reset gating.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, ignored while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Implication checked on every rising edge: when ante holds, cons holds next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/pol_pkg.sv
// ----------------------------------------------------------------------------
// pol_pkg
// Types, sizes and codes shared by the positional ordered list.
// ----------------------------------------------------------------------------
`default_nettype none

package pol_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int COUNT_W    = 5;
	localparam int ELEM_W     = 32;
	localparam int POS_W      = 8;

	// command codes
	localparam logic [2:0] FN_INS_FIRST = 3'd0;
	localparam logic [2:0] FN_INS_LAST  = 3'd1;
	localparam logic [2:0] FN_INS_AT    = 3'd2;
	localparam logic [2:0] FN_DEL_FIRST = 3'd3;
	localparam logic [2:0] FN_DEL_LAST  = 3'd4;
	localparam logic [2:0] FN_DEL_AT    = 3'd5;
	localparam logic [2:0] FN_DISPLAY   = 3'd6;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_BAD  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef logic signed [DATA_WIDTH-1:0] data_t;

	typedef struct packed {
		logic [2:0]              func;
		logic signed [ELEM_W-1:0] value;
		logic [POS_W-1:0]        position;
	} req_t;

	typedef struct packed {
		logic [1:0]              status;
		logic [COUNT_W-1:0]      count;
		logic signed [ELEM_W-1:0] elem_value;
		logic [COUNT_W-1:0]      elem_index;
		logic                    last;
	} rsp_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INS,
		CELL_DEL,
		CELL_ROT
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic [IDX_W-1:0] slot;
		logic [CNT_W-1:0] occ;
	} cell_ctl_t;

	typedef enum logic {
		S_IDLE,
		S_SHOW
	} state_t;

endpackage

`default_nettype wire

### hw/rtl/pol_cell.sv
// ----------------------------------------------------------------------------
// pol_cell
// One list slot: holds a word and takes it from a neighbour on shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module pol_cell import pol_pkg::*; (
	input  logic             clk,
	input  logic [IDX_W-1:0] idx,
	input  cell_ctl_t        ctl,
	input  data_t            ins_d,
	input  data_t            left_d,
	input  data_t            right_d,
	input  data_t            wrap_d,
	output data_t            data
);

	data_t            data_q;
	data_t            data_d;
	logic [CNT_W-1:0] idx_ext;
	logic [CNT_W-1:0] tail;

	assign idx_ext = CNT_W'(idx);
	assign tail    = ctl.occ - 1'b1;

	always_comb begin
		data_d = data_q;
		case (ctl.op)
			CELL_INS: begin
				if (idx == ctl.slot) begin
					data_d = ins_d;
				end else if (idx > ctl.slot) begin
					data_d = left_d;
				end
			end
			CELL_DEL: begin
				if (idx >= ctl.slot) begin
					data_d = right_d;
				end
			end
			CELL_ROT: begin
				// tail slot takes the front word, the rest move one towards the front
				if (idx_ext == tail) begin
					data_d = wrap_d;
				end else if (idx_ext < tail) begin
					data_d = right_d;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

`default_nettype wire

### hw/rtl/positional_ordered_list.sv
// ----------------------------------------------------------------------------
// positional_ordered_list
// Bounded ordered list of signed words held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//  - A request is taken on a rising edge with start high and busy low; it
//    carries func, value and position in req.
//  - Results appear on rsp for one cycle each, marked by strobe. There is
//    no back-pressure: the receiver must take every result as it comes.
//  - Insert, delete and any refused request: one result, in the cycle after
//    the request is taken. busy stays low, so a new request may follow on
//    the very next edge (one request per cycle).
//  - Display of n elements: busy goes high while the list is shown; results
//    follow one per cycle, the first once the display state is entered and
//    its result registered, the last flagged.
//    The row of cells rotates one place per cycle towards the front, so
//    after n steps the list is back in order. Display of an empty list
//    gives a single bad-status result at once.
//  - Reset empties the list (count to zero) and returns to idle; cell
//    contents are not cleared and are never shown before being written.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_ordered_list import pol_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic strobe,
	output rsp_t rsp
);

`include "assert_macros.svh"

	state_t           state_q, state_d;
	logic [CNT_W-1:0] occ_q, occ_d;
	logic [CNT_W-1:0] show_q, show_d;
	logic             strobe_q, strobe_d;
	rsp_t             rsp_q, rsp_d;
	logic [1:0]       st;
	logic [8:0]       pos_ext;
	logic [8:0]       occ_ext;
	logic             show_last;
	cell_ctl_t        ctl;
	data_t            ins_d;
	data_t            cell_w  [CAPACITY];
	data_t            left_w  [CAPACITY];
	data_t            right_w [CAPACITY];

	// incoming word cast to the storage width
	assign ins_d   = DATA_WIDTH'(req.value);
	assign pos_ext = 9'(req.position);
	assign occ_ext = 9'(occ_q);
	assign busy    = (state_q == S_SHOW);

	assign show_last = ((show_q + 1'b1) == occ_q);

	// ---- control: decode the request, drive the cell row, build the result ----
	always_comb begin
		state_d  = state_q;
		occ_d    = occ_q;
		show_d   = show_q;
		strobe_d = 1'b0;
		rsp_d    = '0;
		st       = ST_OK;
		ctl.op   = CELL_HOLD;
		ctl.slot = '0;
		ctl.occ  = occ_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (req.func)
						FN_INS_FIRST, FN_INS_LAST: begin
							if (occ_q >= CNT_W'(CAPACITY)) begin
								st = ST_FULL;
							end else begin
								ctl.op   = CELL_INS;
								ctl.slot = (req.func == FN_INS_FIRST) ? '0 : IDX_W'(occ_q);
								occ_d    = occ_q + 1'b1;
							end
						end
						FN_INS_AT: begin
							// position check takes precedence over the full check
							if (req.position == '0 || pos_ext > occ_ext + 9'd1) begin
								st = ST_BAD;
							end else if (occ_q >= CNT_W'(CAPACITY)) begin
								st = ST_FULL;
							end else begin
								ctl.op   = CELL_INS;
								ctl.slot = IDX_W'(req.position - 1'b1);
								occ_d    = occ_q + 1'b1;
							end
						end
						FN_DEL_FIRST, FN_DEL_LAST: begin
							if (occ_q == '0) begin
								st = ST_BAD;
							end else begin
								ctl.op   = CELL_DEL;
								ctl.slot = (req.func == FN_DEL_FIRST) ? '0 : IDX_W'(occ_q - 1'b1);
								occ_d    = occ_q - 1'b1;
							end
						end
						FN_DEL_AT: begin
							if (req.position == '0 || pos_ext > occ_ext) begin
								st = ST_BAD;
							end else begin
								ctl.op   = CELL_DEL;
								ctl.slot = IDX_W'(req.position - 1'b1);
								occ_d    = occ_q - 1'b1;
							end
						end
						FN_DISPLAY: begin
							if (occ_q == '0) begin
								st = ST_BAD;
							end else begin
								state_d = S_SHOW;
								show_d  = '0;
							end
						end
						default: begin
							st = ST_BAD;
						end
					endcase
					// every request but a non-empty display answers at once
					if (state_d == S_IDLE) begin
						strobe_d     = 1'b1;
						rsp_d.status = st;
						rsp_d.count  = COUNT_W'(occ_d);
						rsp_d.last   = 1'b1;
					end
				end
			end
			S_SHOW: begin
				// emit the front cell while the row rotates
				ctl.op           = CELL_ROT;
				show_d           = show_q + 1'b1;
				strobe_d         = 1'b1;
				rsp_d.status     = ST_OK;
				rsp_d.count      = COUNT_W'(occ_q);
				rsp_d.elem_value = ELEM_W'(cell_w[0]);
				rsp_d.elem_index = COUNT_W'(show_q + 1'b1);
				rsp_d.last       = show_last;
				if (show_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			occ_q    <= '0;
			show_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			occ_q    <= occ_d;
			show_q   <= show_d;
			strobe_q <= strobe_d;
		end
	end

	// result payload: no reset needed, qualified by strobe
	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
	end

	assign strobe = strobe_q;
	assign rsp    = rsp_q;

	// ---- the row of cells; cell 0 is the front ----
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		if (g == 0) begin : g_front
			assign left_w[g] = ins_d;
		end else begin : g_inner
			assign left_w[g] = cell_w[g-1];
		end
		if (g == CAPACITY - 1) begin : g_back
			assign right_w[g] = cell_w[0];
		end else begin : g_body
			assign right_w[g] = cell_w[g+1];
		end

		pol_cell u_cell (
			.clk     (clk),
			.idx     (IDX_W'(g)),
			.ctl     (ctl),
			.ins_d   (ins_d),
			.left_d  (left_w[g]),
			.right_d (right_w[g]),
			.wrap_d  (cell_w[0]),
			.data    (cell_w[g])
		);
	end

	// ---- checks ----
	`ASSERT_CLK(a_occ_bound, clk, arst_n, occ_q <= CNT_W'(CAPACITY), "count above capacity")
	`ASSERT_NEXT(a_show_keeps_count, clk, arst_n, state_q == S_SHOW, occ_q == $past(occ_q), "count moved during display")
	`ASSERT_CLK(a_last_frees, clk, arst_n, (strobe && rsp.last && rsp.elem_index != '0) |-> (state_q == S_IDLE), "still busy after final display result")
	`ASSERT_CLK(a_index_steps, clk, arst_n, (strobe && rsp.elem_index > 5'd1) |-> ($past(strobe) && ($past(rsp.elem_index) + 5'd1 == rsp.elem_index)), "display index not consecutive")

endmodule

`default_nettype wire
